/* hw/rtl/aatb_pkg.sv */
// Package: shared constants for the transformed-box bound core.
package aatb_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int COEF_WIDTH_DEF  = 24;
	localparam int FRAC_BITS       = 16;
	localparam int NUM_LANES       = 3;

endpackage

/* hw/rtl/aatb_affine_transform_bound_core.sv */
// Top level: transformed-box bound for one output axis, three lanes and a merge stage.
// Result strobe done follows the accepting edge through the registers valid_s1, valid_s2 and valid_s3.
// Throughput: one transaction per cycle; busy stays low, set by the 3-stage pipeline
// (multiply, floor and order, sum and saturate).
// Reset: arst_n clears the stage valid bits only; data registers are not reset.
// The receiver cannot stall, so every result is shown for exactly one cycle.
module aabb_affine_transform_bound_core
	import aatb_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int COEF_WIDTH  = COEF_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_WIDTH-1:0] src_min_x,
	input  logic signed [COORD_WIDTH-1:0] src_min_y,
	input  logic signed [COORD_WIDTH-1:0] src_min_z,
	input  logic signed [COORD_WIDTH-1:0] src_max_x,
	input  logic signed [COORD_WIDTH-1:0] src_max_y,
	input  logic signed [COORD_WIDTH-1:0] src_max_z,
	input  logic signed [COEF_WIDTH-1:0]  coef_from_x,
	input  logic signed [COEF_WIDTH-1:0]  coef_from_y,
	input  logic signed [COEF_WIDTH-1:0]  coef_from_z,
	input  logic signed [COORD_WIDTH-1:0] offset,
	output logic                         done,
	output logic signed [COORD_WIDTH-1:0] new_min,
	output logic signed [COORD_WIDTH-1:0] new_max,
	output logic                         saturated
);

	localparam int TERM_WIDTH = COORD_WIDTH + COEF_WIDTH - FRAC_BITS;

	logic signed [COORD_WIDTH-1:0] a_min [NUM_LANES];
	logic signed [COORD_WIDTH-1:0] a_max [NUM_LANES];
	logic signed [COEF_WIDTH-1:0]  coef  [NUM_LANES];
	logic signed [TERM_WIDTH-1:0]  term_lo_s2 [NUM_LANES];
	logic signed [TERM_WIDTH-1:0]  term_hi_s2 [NUM_LANES];
	logic signed [COORD_WIDTH-1:0] offset_s1;
	logic signed [COORD_WIDTH-1:0] offset_s2;
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;

	assign busy = 1'b0;

	assign a_min[0] = src_min_x;
	assign a_min[1] = src_min_y;
	assign a_min[2] = src_min_z;
	assign a_max[0] = src_max_x;
	assign a_max[1] = src_max_y;
	assign a_max[2] = src_max_z;
	assign coef[0]  = coef_from_x;
	assign coef[1]  = coef_from_y;
	assign coef[2]  = coef_from_z;

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		aatb_lane #(
			.COORD_WIDTH(COORD_WIDTH),
			.COEF_WIDTH (COEF_WIDTH)
		) u_lane (
			.clk       (clk),
			.a_min     (a_min[g]),
			.a_max     (a_max[g]),
			.coef      (coef[g]),
			.term_lo_s2(term_lo_s2[g]),
			.term_hi_s2(term_hi_s2[g])
		);
	end

	always_ff @(posedge clk) begin
		offset_s1 <= offset;
		offset_s2 <= offset_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	aatb_merge #(
		.COORD_WIDTH(COORD_WIDTH),
		.COEF_WIDTH (COEF_WIDTH)
	) u_merge (
		.clk       (clk),
		.offset_s2 (offset_s2),
		.term_lo_s2(term_lo_s2),
		.term_hi_s2(term_hi_s2),
		.new_min_s3(new_min),
		.new_max_s3(new_max),
		.sat_s3    (saturated)
	);

	assign done = valid_s3;

endmodule

/* hw/rtl/aatb_lane.sv */
// Lane: multiplies one matrix entry by both source corners, floors, orders the pair.
module aatb_lane
	import aatb_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
	localparam int PROD_WIDTH = COORD_WIDTH + COEF_WIDTH,
	localparam int TERM_WIDTH = PROD_WIDTH - FRAC_BITS
) (
	input  logic                         clk,
	input  logic signed [COORD_WIDTH-1:0] a_min,
	input  logic signed [COORD_WIDTH-1:0] a_max,
	input  logic signed [COEF_WIDTH-1:0]  coef,
	output logic signed [TERM_WIDTH-1:0]  term_lo_s2,
	output logic signed [TERM_WIDTH-1:0]  term_hi_s2
);

	logic signed [PROD_WIDTH-1:0] prod_min;
	logic signed [PROD_WIDTH-1:0] prod_max;
	logic signed [PROD_WIDTH-1:0] prod_min_s1;
	logic signed [PROD_WIDTH-1:0] prod_max_s1;
	logic signed [TERM_WIDTH-1:0] pa;
	logic signed [TERM_WIDTH-1:0] pb;

	assign prod_min = a_min * coef;
	assign prod_max = a_max * coef;

	always_ff @(posedge clk) begin
		prod_min_s1 <= prod_min;
		prod_max_s1 <= prod_max;
	end

	// arithmetic drop of fraction bits = floor
	assign pa = prod_min_s1[PROD_WIDTH-1:FRAC_BITS];
	assign pb = prod_max_s1[PROD_WIDTH-1:FRAC_BITS];

	always_ff @(posedge clk) begin
		if (pa < pb) begin
			term_lo_s2 <= pa;
			term_hi_s2 <= pb;
		end else begin
			term_lo_s2 <= pb;
			term_hi_s2 <= pa;
		end
	end

endmodule

/* hw/rtl/aatb_merge.sv */
// Merge: adds offset and lane terms exactly, then saturates both bounds.
module aatb_merge
	import aatb_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
	localparam int TERM_WIDTH = COORD_WIDTH + COEF_WIDTH - FRAC_BITS,
	localparam int BASE_WIDTH = (TERM_WIDTH > COORD_WIDTH) ? TERM_WIDTH : COORD_WIDTH,
	localparam int SUM_WIDTH  = BASE_WIDTH + 3
) (
	input  logic                         clk,
	input  logic signed [COORD_WIDTH-1:0] offset_s2,
	input  logic signed [TERM_WIDTH-1:0]  term_lo_s2 [NUM_LANES],
	input  logic signed [TERM_WIDTH-1:0]  term_hi_s2 [NUM_LANES],
	output logic signed [COORD_WIDTH-1:0] new_min_s3,
	output logic signed [COORD_WIDTH-1:0] new_max_s3,
	output logic                         sat_s3
);

	logic signed [SUM_WIDTH-1:0] sum_lo;
	logic signed [SUM_WIDTH-1:0] sum_hi;
	logic signed [COORD_WIDTH-1:0] lo_clamped;
	logic signed [COORD_WIDTH-1:0] hi_clamped;
	logic lo_ovf;
	logic hi_ovf;

	localparam logic [COORD_WIDTH-1:0] MAX_VAL = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] MIN_VAL = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	always_comb begin
		sum_lo = SUM_WIDTH'(offset_s2);
		sum_hi = SUM_WIDTH'(offset_s2);
		for (int i = 0; i < NUM_LANES; i++) begin
			sum_lo = sum_lo + SUM_WIDTH'(term_lo_s2[i]);
			sum_hi = sum_hi + SUM_WIDTH'(term_hi_s2[i]);
		end
	end

	// overflow when bits above the result sign disagree with it
	assign lo_ovf = !((&sum_lo[SUM_WIDTH-1:COORD_WIDTH-1]) || !(|sum_lo[SUM_WIDTH-1:COORD_WIDTH-1]));
	assign hi_ovf = !((&sum_hi[SUM_WIDTH-1:COORD_WIDTH-1]) || !(|sum_hi[SUM_WIDTH-1:COORD_WIDTH-1]));

	assign lo_clamped = lo_ovf ? (sum_lo[SUM_WIDTH-1] ? MIN_VAL : MAX_VAL)
	                           : sum_lo[COORD_WIDTH-1:0];
	assign hi_clamped = hi_ovf ? (sum_hi[SUM_WIDTH-1] ? MIN_VAL : MAX_VAL)
	                           : sum_hi[COORD_WIDTH-1:0];

	always_ff @(posedge clk) begin
		new_min_s3 <= lo_clamped;
		new_max_s3 <= hi_clamped;
		sat_s3     <= lo_ovf | hi_ovf;
	end

endmodule
